// ===== hdl/sdato_pkg.sv =====
// ----------------------------------------------------------------------------
// sdato_pkg
// Shared types and constants for the sticky dual-antenna tag owner table.
// ----------------------------------------------------------------------------
package sdato_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_RSSI_FLOOR      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLAIM_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_READS       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_DOMINANCE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_DOMINANCE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNSEEN_LIMIT    = 3'd5;

    // register reset values
    localparam logic signed [15:0] RST_RSSI_FLOOR      = -16'sd800;
    localparam logic [14:0]        RST_CLAIM_MARGIN    = 15'd15;
    localparam logic [7:0]         RST_MIN_READS       = 8'd1;
    localparam logic [3:0]         RST_FIRST_DOMINANCE = 4'd2;
    localparam logic [3:0]         RST_FLIP_DOMINANCE  = 4'd3;
    localparam logic [7:0]         RST_UNSEEN_LIMIT    = 8'd8;

    localparam logic [1:0]         OWNER_NONE = 2'd2;
    localparam logic signed [15:0] RSSI_NONE  = 16'sh8000;
    localparam logic [7:0]         UNSEEN_MAX = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_UPD,
        S_CLS,
        S_ESCAN,
        S_ELOAD,
        S_EMPTY
    } t_state;

endpackage

// ===== hdl/sticky_dual_antenna_tag_owner.sv =====
// ----------------------------------------------------------------------------
// sticky_dual_antenna_tag_owner
// Tag table with per-window read counting and sticky antenna ownership.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  ---------------------------------
//  in        to block   i_in_valid / o_in_stall        command, antenna, rssi, key
//  out       from block o_out_valid / i_out_stall      shown valid/owner/rssi/key/last
//  cfg       to block   i_cfg_valid / o_cfg_ready      register index, write data
//
//  A read report runs the key search, which streams every slot through the single read
//  port of the slot memory; the update state then writes the slot back.
//  A window close runs the rule pass for every slot through the shared arbitration unit,
//  then two emit sweeps, one per owner group, that load each shown entry into the output
//  register (waiting while the output is stalled); with nothing shown, one empty result.
//  Reset clears the in-use bits and the configuration; the slot memory needs no clearing.
//  A stalled result holds in the output register; the block stalls input while busy.
//
module sticky_dual_antenna_tag_owner
    import sdato_pkg::*;
#(
    parameter int TABLE_DEPTH = sdato_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = sdato_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic                                  i_antenna,
    input  logic signed [15:0]                    i_read_rssi,
    input  logic [31:0]                           i_key_high,
    input  logic [63:0]                           i_key_low,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_shown_valid,
    output logic                                  o_shown_owner,
    output logic signed [15:0]                    o_shown_rssi,
    output logic [31:0]                           o_shown_key_high,
    output logic [63:0]                           o_shown_key_low,
    output logic                                  o_shown_last,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sdato_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sdato_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam int PW = COUNT_BITS + 4;
    localparam logic [IW:0]   DEPTH_L = (IW+1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_L  = IW'(TABLE_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] r_rssi_floor;
    logic [14:0]        r_claim_margin;
    logic [7:0]         r_min_reads;
    logic [3:0]         r_first_dom;
    logic [3:0]         r_flip_dom;
    logic [7:0]         r_unseen_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rssi_floor   <= RST_RSSI_FLOOR;
            r_claim_margin <= RST_CLAIM_MARGIN;
            r_min_reads    <= RST_MIN_READS;
            r_first_dom    <= RST_FIRST_DOMINANCE;
            r_flip_dom     <= RST_FLIP_DOMINANCE;
            r_unseen_limit <= RST_UNSEEN_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RSSI_FLOOR:      r_rssi_floor   <= i_cfg_data;
                CFG_CLAIM_MARGIN:    r_claim_margin <= i_cfg_data[14:0];
                CFG_MIN_READS:       r_min_reads    <= i_cfg_data[7:0];
                CFG_FIRST_DOMINANCE: r_first_dom    <= i_cfg_data[3:0];
                CFG_FLIP_DOMINANCE:  r_flip_dom     <= i_cfg_data[3:0];
                CFG_UNSEEN_LIMIT:    r_unseen_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Slot memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [31:0]           mem_kh    [TABLE_DEPTH];
    logic [63:0]           mem_kl    [TABLE_DEPTH];
    logic [1:0]            mem_owner [TABLE_DEPTH];
    logic [15:0]           mem_orssi [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] mem_c0    [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] mem_c1    [TABLE_DEPTH];
    logic [15:0]           mem_p0    [TABLE_DEPTH];
    logic [15:0]           mem_p1    [TABLE_DEPTH];
    logic [7:0]            mem_unseen[TABLE_DEPTH];

    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [31:0]           wr_kh;
    logic [63:0]           wr_kl;
    logic [1:0]            wr_owner;
    logic signed [15:0]    wr_orssi;
    logic [COUNT_BITS-1:0] wr_c0, wr_c1;
    logic signed [15:0]    wr_p0, wr_p1;
    logic [7:0]            wr_unseen;

    logic [31:0]           r_rd_kh;
    logic [63:0]           r_rd_kl;
    logic [1:0]            r_rd_owner;
    logic signed [15:0]    r_rd_orssi;
    logic [COUNT_BITS-1:0] r_rd_c0, r_rd_c1;
    logic signed [15:0]    r_rd_p0, r_rd_p1;
    logic [7:0]            r_rd_unseen;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_kh[wr_addr]     <= wr_kh;
            mem_kl[wr_addr]     <= wr_kl;
            mem_owner[wr_addr]  <= wr_owner;
            mem_orssi[wr_addr]  <= wr_orssi;
            mem_c0[wr_addr]     <= wr_c0;
            mem_c1[wr_addr]     <= wr_c1;
            mem_p0[wr_addr]     <= wr_p0;
            mem_p1[wr_addr]     <= wr_p1;
            mem_unseen[wr_addr] <= wr_unseen;
        end
        if (rd_en) begin
            r_rd_kh     <= mem_kh[rd_addr];
            r_rd_kl     <= mem_kl[rd_addr];
            r_rd_owner  <= mem_owner[rd_addr];
            r_rd_orssi  <= mem_orssi[rd_addr];
            r_rd_c0     <= mem_c0[rd_addr];
            r_rd_c1     <= mem_c1[rd_addr];
            r_rd_p0     <= mem_p0[rd_addr];
            r_rd_p1     <= mem_p1[rd_addr];
            r_rd_unseen <= mem_unseen[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [IW:0]      r_idx;      // next slot to read
    logic             r_pv;       // read data of r_pidx is present
    logic [IW-1:0]    r_pidx;
    logic             r_grp;      // owner group being emitted
    logic [TW-1:0]    r_total;    // entries shown this window
    logic [TW-1:0]    r_sent;
    logic [TW-1:0]    n_sent;

    logic [TABLE_DEPTH-1:0] r_in_use;
    logic [TABLE_DEPTH-1:0] r_show;
    logic [TABLE_DEPTH-1:0] r_show_own;

    // accepted item
    logic               r_ant;
    logic signed [15:0] r_rssi;
    logic [31:0]        r_kh;
    logic [63:0]        r_kl;

    // lookup results
    logic                  r_hit, r_free;
    logic [IW-1:0]         r_hit_idx, r_free_idx;
    logic [1:0]            r_h_owner;
    logic signed [15:0]    r_h_orssi;
    logic [COUNT_BITS-1:0] r_h_c0, r_h_c1;
    logic signed [15:0]    r_h_p0, r_h_p1;
    logic [7:0]            r_h_unseen;

    // output register
    logic               r_ov;
    logic               r_o_sv;
    logic               r_o_own;
    logic signed [15:0] r_o_rssi;
    logic [31:0]        r_o_kh;
    logic [63:0]        r_o_kl;
    logic               r_o_last;

    logic in_acc;
    logic out_free;
    logic out_load;
    logic key_match;
    logic scan_end;
    logic emit_hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_ov || !i_out_stall;
    assign out_load    = out_free && ((r_state == S_ELOAD) || (r_state == S_EMPTY));
    assign key_match   = r_in_use[r_pidx] && (r_rd_kh == r_kh) && (r_rd_kl == r_kl);
    assign scan_end    = r_pv && (r_pidx == LAST_L);
    assign emit_hit    = r_show[r_idx[IW-1:0]] && (r_show_own[r_idx[IW-1:0]] == r_grp);
    assign n_sent      = r_sent + TW'(1);

    assign o_out_valid      = r_ov;
    assign o_shown_valid    = r_o_sv;
    assign o_shown_owner    = r_o_own;
    assign o_shown_rssi     = r_o_rssi;
    assign o_shown_key_high = r_o_kh;
    assign o_shown_key_low  = r_o_kl;
    assign o_shown_last     = r_o_last;

    // ------------------------------------------------------------------
    // Shared arbitration unit: window-close rules for the slot just read
    // ------------------------------------------------------------------
    logic                  a_evict;
    logic                  a_show;
    logic                  a_shown;
    logic [1:0]            a_owner;
    logic signed [15:0]    a_orssi;
    logic [7:0]            a_unseen;
    logic signed [16:0]    a_margin;
    logic signed [16:0]    a_cm;
    logic [PW-1:0]         a_fd_c0, a_fd_c1, a_fl_ot;
    logic                  a_own_new;
    logic                  a_own;
    logic                  a_ch;
    logic                  a_ot;
    logic [COUNT_BITS-1:0] a_cc, a_cot, a_cown, a_cnew;
    logic signed [15:0]    a_pown, a_pch, a_pnew;
    logic                  a_flip;

    always_comb begin
        a_evict   = 1'b0;
        a_show    = 1'b0;
        a_owner   = r_rd_owner;
        a_orssi   = r_rd_orssi;
        a_unseen  = r_rd_unseen;
        a_margin  = {r_rd_p0[15], r_rd_p0} - {r_rd_p1[15], r_rd_p1};
        a_cm      = {2'b00, r_claim_margin};
        a_fd_c0   = PW'(r_first_dom) * PW'(r_rd_c0);
        a_fd_c1   = PW'(r_first_dom) * PW'(r_rd_c1);
        a_own     = r_rd_owner[0];
        a_cown    = a_own ? r_rd_c1 : r_rd_c0;
        a_pown    = a_own ? r_rd_p1 : r_rd_p0;
        if (r_rd_c0 > r_rd_c1) begin
            a_ch = 1'b0;
        end else if (r_rd_c1 > r_rd_c0) begin
            a_ch = 1'b1;
        end else begin
            a_ch = (r_rd_p0 >= r_rd_p1) ? 1'b0 : 1'b1;
        end
        a_ot      = ~a_ch;
        a_cc      = a_ch ? r_rd_c1 : r_rd_c0;
        a_cot     = a_ot ? r_rd_c1 : r_rd_c0;
        a_pch     = a_ch ? r_rd_p1 : r_rd_p0;
        a_fl_ot   = PW'(r_flip_dom) * PW'(a_cot);
        a_flip    = (a_cot == '0) ? (MW'(a_cc) >= MW'(r_flip_dom))
                                  : (PW'(a_cc) >= a_fl_ot);
        // first-claim candidate
        if (r_rd_c1 == '0) begin
            a_own_new = 1'b0;
        end else if (r_rd_c0 == '0) begin
            a_own_new = 1'b1;
        end else if (r_rd_c0 > r_rd_c1) begin
            a_own_new = 1'b0;
        end else if (r_rd_c1 > r_rd_c0) begin
            a_own_new = 1'b1;
        end else if (a_margin >= a_cm) begin
            a_own_new = 1'b0;
        end else if (a_margin <= -a_cm) begin
            a_own_new = 1'b1;
        end else if (PW'(r_rd_c0) >= a_fd_c1) begin
            a_own_new = 1'b0;
        end else if (PW'(r_rd_c1) >= a_fd_c0) begin
            a_own_new = 1'b1;
        end else begin
            a_own_new = (r_rd_p0 >= r_rd_p1) ? 1'b0 : 1'b1;
        end
        a_cnew = a_own_new ? r_rd_c1 : r_rd_c0;
        a_pnew = a_own_new ? r_rd_p1 : r_rd_p0;

        if (r_rd_c0 == '0 && r_rd_c1 == '0) begin
            a_unseen = (r_rd_unseen == UNSEEN_MAX) ? r_rd_unseen : r_rd_unseen + 8'd1;
            a_evict  = (a_unseen >= r_unseen_limit);
            a_show   = (r_rd_owner != OWNER_NONE);
        end else begin
            a_unseen = '0;
            if (r_rd_owner == OWNER_NONE) begin
                if (MW'(a_cnew) >= MW'(r_min_reads) && a_pnew >= r_rssi_floor) begin
                    a_owner = {1'b0, a_own_new};
                    a_orssi = a_pnew;
                    a_show  = 1'b1;
                end
            end else begin
                if (a_cown != '0) begin
                    a_orssi = a_pown;
                end
                if (a_ch != a_own && a_flip) begin
                    a_owner = {1'b0, a_ch};
                    a_orssi = a_pch;
                end
                a_show = 1'b1;
            end
        end
        a_shown = a_show && (a_owner != OWNER_NONE);
    end

    // ------------------------------------------------------------------
    // Next state, memory port control
    // ------------------------------------------------------------------
    logic                  u_ant_hit;
    logic [COUNT_BITS-1:0] u_c0, u_c1;
    logic signed [15:0]    u_p0, u_p1;

    always_comb begin
        // base entry for a read report: the hit slot, or a fresh one
        u_c0 = r_hit ? r_h_c0 : '0;
        u_c1 = r_hit ? r_h_c1 : '0;
        u_p0 = r_hit ? r_h_p0 : RSSI_NONE;
        u_p1 = r_hit ? r_h_p1 : RSSI_NONE;
        u_ant_hit = r_ant;
        if (!u_ant_hit) begin
            if (u_c0 != CNT_MAX) u_c0 = u_c0 + COUNT_BITS'(1);
            if (r_rssi > u_p0)   u_p0 = r_rssi;
        end else begin
            if (u_c1 != CNT_MAX) u_c1 = u_c1 + COUNT_BITS'(1);
            if (r_rssi > u_p1)   u_p1 = r_rssi;
        end

        n_state   = r_state;
        rd_en     = 1'b0;
        rd_addr   = r_idx[IW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pidx;
        wr_kh     = r_rd_kh;
        wr_kl     = r_rd_kl;
        wr_owner  = a_owner;
        wr_orssi  = a_orssi;
        wr_c0     = '0;
        wr_c1     = '0;
        wr_p0     = RSSI_NONE;
        wr_p1     = RSSI_NONE;
        wr_unseen = a_unseen;

        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = i_command ? S_CLS : S_LOOK;
            end
            S_LOOK: begin
                rd_en = (r_idx < DEPTH_L);
                if (scan_end) n_state = S_UPD;
            end
            S_UPD: begin
                wr_en     = r_hit || r_free;
                wr_addr   = r_hit ? r_hit_idx : r_free_idx;
                wr_kh     = r_kh;
                wr_kl     = r_kl;
                wr_owner  = r_hit ? r_h_owner : OWNER_NONE;
                wr_orssi  = r_hit ? r_h_orssi : RSSI_NONE;
                wr_unseen = r_hit ? r_h_unseen : 8'd0;
                wr_c0     = u_c0;
                wr_c1     = u_c1;
                wr_p0     = u_p0;
                wr_p1     = u_p1;
                n_state   = S_IDLE;
            end
            S_CLS: begin
                rd_en = (r_idx < DEPTH_L);
                wr_en = r_pv && r_in_use[r_pidx] && !a_evict;
                if (scan_end) begin
                    if (r_total == '0 && !(r_in_use[r_pidx] && !a_evict && a_shown)) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_ESCAN;
                    end
                end
            end
            S_ESCAN: begin
                if (r_idx == DEPTH_L) begin
                    if (r_grp) n_state = S_IDLE;
                end else if (emit_hit) begin
                    rd_en   = 1'b1;
                    n_state = S_ELOAD;
                end
            end
            S_ELOAD: begin
                if (out_free) n_state = S_ESCAN;
            end
            S_EMPTY: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_grp    <= 1'b0;
            r_total  <= '0;
            r_sent   <= '0;
            r_in_use <= '0;
            r_show   <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            // load a new result, or drop the old one once it is taken
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // hold the item for the whole walk
                        r_ant   <= i_antenna;
                        r_rssi  <= i_read_rssi;
                        r_kh    <= i_key_high;
                        r_kl    <= i_key_low;
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_total <= '0;
                        r_show  <= '0;
                    end
                end
                S_LOOK: begin
                    r_pv   <= (r_idx < DEPTH_L);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < DEPTH_L) r_idx <= r_idx + 1'b1;
                    if (r_pv) begin
                        if (key_match && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_pidx;
                            r_h_owner  <= r_rd_owner;
                            r_h_orssi  <= r_rd_orssi;
                            r_h_c0     <= r_rd_c0;
                            r_h_c1     <= r_rd_c1;
                            r_h_p0     <= r_rd_p0;
                            r_h_p1     <= r_rd_p1;
                            r_h_unseen <= r_rd_unseen;
                        end
                        if (!r_in_use[r_pidx] && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                    end
                end
                S_UPD: begin
                    // a new key takes the lowest free slot; a full table drops it
                    if (!r_hit && r_free) r_in_use[r_free_idx] <= 1'b1;
                end
                S_CLS: begin
                    r_pv   <= (r_idx < DEPTH_L);
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < DEPTH_L) r_idx <= r_idx + 1'b1;
                    if (r_pv && r_in_use[r_pidx]) begin
                        if (a_evict) begin
                            r_in_use[r_pidx] <= 1'b0;
                        end else begin
                            r_show[r_pidx]     <= a_shown;
                            r_show_own[r_pidx] <= a_owner[0];
                            if (a_shown) r_total <= r_total + TW'(1);
                        end
                    end
                    if (scan_end) begin
                        r_idx  <= '0;
                        r_grp  <= 1'b0;
                        r_sent <= '0;
                    end
                end
                S_ESCAN: begin
                    if (r_idx == DEPTH_L) begin
                        if (!r_grp) begin
                            r_grp <= 1'b1;
                            r_idx <= '0;
                        end
                    end else if (!emit_hit) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ELOAD: begin
                    if (out_free) begin
                        r_o_sv   <= 1'b1;
                        r_o_own  <= r_grp;
                        r_o_rssi <= r_rd_orssi;
                        r_o_kh   <= r_rd_kh;
                        r_o_kl   <= r_rd_kl;
                        r_o_last <= (n_sent == r_total);
                        r_sent   <= n_sent;
                        r_idx    <= r_idx + 1'b1;
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_o_sv   <= 1'b0;
                        r_o_own  <= 1'b0;
                        r_o_rssi <= '0;
                        r_o_kh   <= '0;
                        r_o_kl   <= '0;
                        r_o_last <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // never emit more entries than the rule pass counted
    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELOAD) |-> (r_sent < r_total))
        else $error("emit count overran shown total");

    // an empty window result is always the final one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_shown_valid) |-> o_shown_last)
        else $error("empty result without last flag");

    // rule write-back never collides with the look-ahead read
    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same slot");

    // a stalled result stays valid until it has been taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ===== dv/tb_sticky_dual_antenna_tag_owner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sticky_dual_antenna_tag_owner
// Self-checking bench for the sticky dual-antenna tag owner table.
// Runs a short directed table and then random read windows through the
// block. Results are checked against an in-bench model of the tag table,
// under several register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sticky_dual_antenna_tag_owner;
    import sdato_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CNT_MAX   = 65535;
    localparam int CYC_LIMIT = 1500000;
    localparam int POOL      = 16;

    typedef struct {
        bit                 vld;
        bit                 own;
        logic signed [15:0] rssi;
        logic [31:0]        kh;
        logic [63:0]        kl;
        bit                 last;
    } t_shown;

    typedef struct {
        bit                 cmd;
        bit                 ant;
        logic signed [15:0] rssi;
        logic [31:0]        kh;
        logic [63:0]        kl;
        bit                 typed;
        t_shown             res;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_command;
    logic               i_antenna;
    logic signed [15:0] i_read_rssi;
    logic [31:0]        i_key_high;
    logic [63:0]        i_key_low;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_shown_valid;
    logic               o_shown_owner;
    logic signed [15:0] o_shown_rssi;
    logic [31:0]        o_shown_key_high;
    logic [63:0]        o_shown_key_low;
    logic               o_shown_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    sticky_dual_antenna_tag_owner dut (.*);

    // clock: 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // model of the tag table
    bit          used     [DEPTH];
    logic [31:0] tag_hi   [DEPTH];
    logic [63:0] tag_lo   [DEPTH];
    logic [1:0]  owner    [DEPTH];
    int          own_rssi [DEPTH];
    int          reads0   [DEPTH];
    int          reads1   [DEPTH];
    int          peak0    [DEPTH];
    int          peak1    [DEPTH];
    int          unseen   [DEPTH];

    int cf_floor, cf_margin, cf_min, cf_first, cf_flip, cf_unseen;

    t_shown shown_q[$];
    int     n_items, n_results, n_errors, n_closes, n_cfg;
    int     cycles;
    bit     no_idle;
    int     rx_hold;

    logic [31:0] pool_hi [POOL];
    logic [63:0] pool_lo [POOL];

    function automatic void clear_window(int i);
        reads0[i] = 0;
        reads1[i] = 0;
        peak0[i]  = -32768;
        peak1[i]  = -32768;
    endfunction

    function automatic void count_read(bit ant, int rssi, logic [31:0] kh, logic [63:0] kl);
        int hit;
        int fr;
        hit = -1;
        fr  = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (used[i]) begin
                if (hit < 0 && tag_hi[i] == kh && tag_lo[i] == kl) hit = i;
            end else if (fr < 0) begin
                fr = i;
            end
        end
        if (hit < 0) begin
            // table full: drop the read
            if (fr < 0) return;
            hit = fr;
            used[hit]     = 1'b1;
            tag_hi[hit]   = kh;
            tag_lo[hit]   = kl;
            owner[hit]    = OWNER_NONE;
            own_rssi[hit] = -32768;
            unseen[hit]   = 0;
            clear_window(hit);
        end
        if (!ant) begin
            if (reads0[hit] < CNT_MAX) reads0[hit]++;
            if (rssi > peak0[hit]) peak0[hit] = rssi;
        end else begin
            if (reads1[hit] < CNT_MAX) reads1[hit]++;
            if (rssi > peak1[hit]) peak1[hit] = rssi;
        end
    endfunction

    function automatic bit claim_owner(int i);
        longint c0, c1;
        int     r0, r1, margin;
        bit     own;
        c0 = reads0[i];
        c1 = reads1[i];
        r0 = peak0[i];
        r1 = peak1[i];
        margin = r0 - r1;
        if (c0 == 0 && c1 == 0) return 1'b0;
        if (c1 == 0) own = 0;
        else if (c0 == 0) own = 1;
        else if (c0 > c1) own = 0;
        else if (c1 > c0) own = 1;
        else if (margin >= cf_margin) own = 0;
        else if (margin <= -cf_margin) own = 1;
        else if (c0 >= cf_first * c1) own = 0;
        else if (c1 >= cf_first * c0) own = 1;
        else own = (r0 >= r1) ? 1'b0 : 1'b1;
        if ((own ? c1 : c0) < cf_min) return 1'b0;
        if ((own ? r1 : r0) < cf_floor) return 1'b0;
        owner[i]    = {1'b0, own};
        own_rssi[i] = own ? r1 : r0;
        return 1'b1;
    endfunction

    function automatic bit settle_slot(int i);
        longint c[2];
        int     p[2];
        bit     ch, ot, own, flip;
        c[0] = reads0[i];
        c[1] = reads1[i];
        p[0] = peak0[i];
        p[1] = peak1[i];
        if (c[0] == 0 && c[1] == 0) begin
            if (unseen[i] < 255) unseen[i]++;
            if (unseen[i] >= cf_unseen) used[i] = 1'b0;
            return owner[i] != OWNER_NONE;
        end
        unseen[i] = 0;
        if (owner[i] == OWNER_NONE) return claim_owner(i);
        own = owner[i][0];
        if (c[own] > 0) own_rssi[i] = p[own];
        if (c[0] > c[1]) ch = 0;
        else if (c[1] > c[0]) ch = 1;
        else ch = (p[0] >= p[1]) ? 1'b0 : 1'b1;
        ot = ~ch;
        if (ch != own) begin
            if (c[ot] == 0) flip = c[ch] >= cf_flip;
            else flip = c[ch] >= cf_flip * c[ot];
            if (flip) begin
                owner[i]    = {1'b0, ch};
                own_rssi[i] = p[ch];
            end
        end
        return 1'b1;
    endfunction

    // window close: settle every slot, then queue the owned entries per antenna
    function automatic void close_window();
        bit     shown[DEPTH];
        int     n;
        t_shown r;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shown[i] = 1'b0;
            if (used[i]) begin
                shown[i] = settle_slot(i);
                if (used[i]) begin
                    shown[i] = shown[i] && owner[i] != OWNER_NONE;
                    clear_window(i);
                end else begin
                    shown[i] = 1'b0;
                end
            end
        end
        for (int g = 0; g < 2; g++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (shown[i] && owner[i] == g) begin
                    r.vld  = 1'b1;
                    r.own  = g[0];
                    r.rssi = own_rssi[i][15:0];
                    r.kh   = tag_hi[i];
                    r.kl   = tag_lo[i];
                    r.last = 1'b0;
                    shown_q.push_back(r);
                    n++;
                end
            end
        end
        if (n == 0) begin
            r = '{vld: 1'b0, own: 1'b0, rssi: '0, kh: '0, kl: '0, last: 1'b1};
            shown_q.push_back(r);
        end else begin
            shown_q[shown_q.size()-1].last = 1'b1;
        end
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("%0t timeout, %0d results still awaited", $realtime, shown_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_shown e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (shown_q.size() == 0) begin
                $display("%0t unexpected result: expected none, got key %h_%h",
                         $realtime, o_shown_key_high, o_shown_key_low);
                n_errors++;
            end else begin
                e = shown_q.pop_front();
                if (o_shown_valid !== e.vld) begin
                    $display("%0t shown_valid expected %0d got %0d", $realtime, e.vld,
                             o_shown_valid);
                    n_errors++;
                end
                if (o_shown_owner !== e.own) begin
                    $display("%0t shown_owner expected %0d got %0d", $realtime, e.own,
                             o_shown_owner);
                    n_errors++;
                end
                if (o_shown_rssi !== e.rssi) begin
                    $display("%0t shown_rssi expected %0d got %0d", $realtime, e.rssi,
                             o_shown_rssi);
                    n_errors++;
                end
                if (o_shown_key_high !== e.kh) begin
                    $display("%0t shown_key_high expected %h got %h", $realtime, e.kh,
                             o_shown_key_high);
                    n_errors++;
                end
                if (o_shown_key_low !== e.kl) begin
                    $display("%0t shown_key_low expected %h got %h", $realtime, e.kl,
                             o_shown_key_low);
                    n_errors++;
                end
                if (o_shown_last !== e.last) begin
                    $display("%0t shown_last expected %0d got %0d", $realtime, e.last,
                             o_shown_last);
                    n_errors++;
                end
            end
        end
    end

    // result side: random stall before each transfer, plus an optional long hold-off
    initial begin
        int w;
        i_out_stall <= 1'b1;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            w = no_idle ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // offer one item after a random gap; predict once the transfer is taken
    task automatic send_item(bit cmd, bit ant, logic signed [15:0] rssi,
                             logic [31:0] kh, logic [63:0] kl,
                             bit typed = 1'b0, t_shown res = '{default: '0});
        int gap;
        int sz;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_antenna   <= ant;
        i_read_rssi <= rssi;
        i_key_high  <= kh;
        i_key_low   <= kl;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (!cmd) begin
            count_read(ant, rssi, kh, kl);
        end else begin
            n_closes++;
            sz = shown_q.size();
            close_window();
            if (typed) begin
                while (shown_q.size() > sz) void'(shown_q.pop_back());
                shown_q.push_back(res);
            end
        end
        @(negedge i_clk);
    endtask

    // hold the input and wait for all results, then for any read still in flight
    task automatic drain();
        i_in_valid <= 1'b0;
        while (shown_q.size() != 0) @(negedge i_clk);
        repeat (DEPTH + 40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg++;
        case (idx)
            CFG_RSSI_FLOOR:      cf_floor  = $signed(val);
            CFG_CLAIM_MARGIN:    cf_margin = val[14:0];
            CFG_MIN_READS:       cf_min    = val[7:0];
            CFG_FIRST_DOMINANCE: cf_first  = val[3:0];
            CFG_FLIP_DOMINANCE:  cf_flip   = val[3:0];
            CFG_UNSEEN_LIMIT:    cf_unseen = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(int fl, int mg, int mn, int fd, int fp, int us);
        write_reg(CFG_RSSI_FLOOR, fl[15:0]);
        write_reg(CFG_CLAIM_MARGIN, mg[15:0]);
        write_reg(CFG_MIN_READS, mn[15:0]);
        write_reg(CFG_FIRST_DOMINANCE, fd[15:0]);
        write_reg(CFG_FLIP_DOMINANCE, fp[15:0]);
        write_reg(CFG_UNSEEN_LIMIT, us[15:0]);
    endtask

    function automatic logic signed [15:0] pick_rssi();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 1200) - 1000);
    endfunction

    t_stim_row dir_tab [0:16];

    initial begin
        localparam logic [31:0] HA = 32'h5555_5555;
        localparam logic [31:0] HB = 32'hAAAA_AAAA;
        localparam logic [63:0] LA = 64'hAAAA_AAAA_AAAA_AAAA;
        localparam logic [63:0] LB = 64'h5555_5555_5555_5555;
        localparam logic [31:0] H1 = 32'hFFFF_FFFF;
        localparam logic [63:0] L1 = '1;
        t_shown none_r;
        t_shown rd_r;
        int     sel, k, lim, phase;
        bit     ant;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= 1'b0;
        i_antenna   <= 1'b0;
        i_read_rssi <= '0;
        i_key_high  <= '0;
        i_key_low   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cycles = 0; n_items = 0; n_results = 0; n_errors = 0; n_closes = 0; n_cfg = 0;
        no_idle = 1'b0;
        rx_hold = 0;
        cf_floor = -800; cf_margin = 15; cf_min = 1; cf_first = 2; cf_flip = 3;
        cf_unseen = 8;
        for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
        for (int i = 0; i < POOL; i++) begin
            pool_hi[i] = $urandom();
            pool_lo[i] = {$urandom(), $urandom()};
        end
        // near twins: same upper half, same lower half, or lower halves one bit apart
        pool_hi[1] = pool_hi[0];
        pool_lo[3] = pool_lo[2];
        pool_hi[5] = pool_hi[4];
        pool_lo[5] = pool_lo[4] ^ 64'h1;

        none_r = '{vld: 1'b0, own: 1'b0, rssi: '0, kh: '0, kl: '0, last: 1'b1};
        rd_r   = '{vld: 1'b1, own: 1'b0, rssi: 16'sh7FFF, kh: H1, kl: L1, last: 1'b1};
        dir_tab = '{
            // close on an empty table: one empty result
            '{1'b1, 1'b0, 16'sd0,      '0, '0, 1'b1, none_r},
            '{1'b0, 1'b0, 16'sh7FFF,   H1, L1, 1'b0, none_r},
            // weakest read stays below the floor, so no claim
            '{1'b0, 1'b1, -16'sd32768, '0, '0, 1'b0, none_r},
            '{1'b1, 1'b0, 16'sd0,      '0, '0, 1'b1, rd_r},
            // equal counts: the stronger peak wins, by a small margin or by a large one
            '{1'b0, 1'b1, -16'sd100,   HA, LA, 1'b0, none_r},
            '{1'b0, 1'b0, -16'sd90,    HA, LA, 1'b0, none_r},
            '{1'b0, 1'b0, -16'sd500,   HB, LB, 1'b0, none_r},
            '{1'b0, 1'b1, -16'sd400,   HB, LB, 1'b0, none_r},
            // owner challenged by three reads on the other antenna: flip
            '{1'b0, 1'b0, -16'sd100,   H1, L1, 1'b0, none_r},
            '{1'b0, 1'b1, 16'sd0,      H1, L1, 1'b0, none_r},
            '{1'b0, 1'b1, 16'sd5,      H1, L1, 1'b0, none_r},
            '{1'b0, 1'b1, -16'sd3,     H1, L1, 1'b0, none_r},
            '{1'b1, 1'b1, 16'sd0,      '0, '0, 1'b0, none_r},
            '{1'b0, 1'b1, -16'sd200,   '0, '0, 1'b0, none_r},
            '{1'b0, 1'b0, -16'sd32768, HA, LA, 1'b0, none_r},
            '{1'b1, 1'b0, 16'sd0,      '0, '0, 1'b0, none_r},
            // empty window: owners still shown
            '{1'b1, 1'b1, 16'sh7FFF,   H1, L1, 1'b0, none_r}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r])
            send_item(dir_tab[r].cmd, dir_tab[r].ant, dir_tab[r].rssi, dir_tab[r].kh,
                      dir_tab[r].kl, dir_tab[r].typed, dir_tab[r].res);

        // random windows; every fourth one starts from idle with new settings
        phase = 0;
        while (n_items < 245) begin
            no_idle = (phase % 7 == 3);
            if (phase % 4 == 0) begin
                drain();
                sel = (phase / 4) % 4;
                case (sel)
                    0: write_all(-800, 15, 1, 2, 3, 8);
                    1: write_all(-32768, 0, 0, 1, 1, 1);
                    2: write_all(32767, 32767, 255, 15, 15, 255);
                    default: write_all($urandom_range(0, 800) - 900, $urandom_range(0, 60),
                                       $urandom_range(0, 3), $urandom_range(1, 15),
                                       $urandom_range(1, 15), $urandom_range(1, 6));
                endcase
            end
            if (phase == 9) begin
                // overflow the table with fresh keys; evict them all afterwards
                drain();
                write_reg(CFG_UNSEEN_LIMIT, 16'd1);
                for (int i = 0; i < DEPTH + 6; i++)
                    send_item(1'b0, 1'($urandom_range(0, 1)), pick_rssi(), $urandom(),
                              {$urandom(), $urandom()});
                send_item(1'b1, 1'b0, '0, '0, '0);
                send_item(1'b1, 1'b0, '0, '0, '0);
            end else if (phase == 6) begin
                // receiver holds off while a close and more reads are offered
                rx_hold = 400;
                for (int i = 0; i < 6; i++)
                    send_item(1'b0, i[0], pick_rssi(), pool_hi[i], pool_lo[i]);
                send_item(1'b1, 1'b0, '0, '0, '0);
                for (int i = 0; i < 4; i++)
                    send_item(1'b0, 1'($urandom_range(0, 1)), pick_rssi(), pool_hi[i],
                              pool_lo[i]);
                send_item(1'b1, 1'b0, '0, '0, '0);
            end else begin
                lim = $urandom_range(0, 14);
                for (int i = 0; i < lim; i++) begin
                    k = $urandom_range(0, 9);
                    if (k == 0) begin
                        // noise: stray key or a random field pattern
                        send_item(1'b0, 1'($urandom_range(0, 1)), 16'($urandom()),
                                  $urandom(), {$urandom(), $urandom()});
                    end else begin
                        k = $urandom_range(0, POOL - 1);
                        // lean each key towards one antenna to exercise dominance
                        ant = ($urandom_range(0, 3) == 0) ? k[0] : ~k[0] ^ phase[2];
                        send_item(1'b0, ant, pick_rssi(), pool_hi[k], pool_lo[k]);
                    end
                end
                send_item(1'b1, 1'($urandom_range(0, 1)), 16'($urandom()), $urandom(),
                          {$urandom(), $urandom()});
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        while (shown_q.size() != 0) @(negedge i_clk);
        repeat (4 * DEPTH) @(negedge i_clk);

        $display("Sent %0d items (%0d window closes), checked %0d results, %0d register writes.",
                 n_items, n_closes, n_results, n_cfg);
        $display("Errors found: %0d", n_errors);
        if (n_errors == 0 && shown_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sdato_pkg.sv
hdl/sticky_dual_antenna_tag_owner.sv
dv/tb_sticky_dual_antenna_tag_owner.sv
